// ===== src/trk_pkg.sv =====
// ----------------------------------------------------------------------------
// trk_pkg
// Shared types and constants of the trickle timer engine.
// ----------------------------------------------------------------------------
package trk_pkg;

	localparam int MS_W      = 32;
	localparam int HEARD_W   = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int US_PER_MS = 1000;
	localparam int SCALED_W  = MS_W + 10;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FACTOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_K      = 2'd2;

	localparam logic [CFG_W-1:0]   RST_MIN    = 16'd100;
	localparam logic [CFG_W-1:0]   RST_FACTOR = 16'd16;
	localparam logic [HEARD_W-1:0] RST_K      = 8'd3;

	typedef enum logic [2:0] {
		CMD_INIT      = 3'd0,
		CMD_RX_CONS   = 3'd1,
		CMD_RX_INCONS = 3'd2,
		CMD_RESET     = 3'd3,
		CMD_TX_REG    = 3'd4,
		CMD_STEP      = 3'd5,
		CMD_TICK      = 3'd6
	} trk_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_DIV,
		S_WRITE,
		S_DONE
	} trk_state_t;

	typedef struct packed {
		logic [MS_W-1:0]    interval_len;
		logic [MS_W-1:0]    tx_point;
		logic [MS_W-1:0]    interval_end;
		logic [HEARD_W-1:0] heard;
		logic               tx_done;
	} trk_rec_t;

endpackage

// ===== src/trickle_timer_engine.sv =====
// ----------------------------------------------------------------------------
// trickle_timer_engine
// Trickle timers for several instances around one state memory, with a
// shared global tick counter.
// ----------------------------------------------------------------------------
// A tick transaction goes from idle straight to the result state. Other
// commands read and evaluate, then write when the record is updated; a new
// interval draws its transmit point first, by the bit-serial remainder unit.
// One transaction is in work at a time; the output register lets the next
// one be accepted while a result waits. Reset loads the registers with their
// defaults and clears the tick counter; memory contents stay undefined.
module trickle_timer_engine #(
	parameter int INSTANCES      = 8,
	parameter int TICK_PERIOD_US = 1000
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [trk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [trk_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      command,
	input  logic [2:0]                      instance_req,
	input  logic [trk_pkg::MS_W-1:0]        start_interval_ms,
	input  logic [trk_pkg::MS_W-1:0]        random_word,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            do_tx,
	output logic                            status
);

	localparam int AW  = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
	localparam int PW  = $clog2(TICK_PERIOD_US + 1);
	localparam int TPW = trk_pkg::MS_W + PW;
	localparam int CW  = (TPW > trk_pkg::SCALED_W) ? TPW : trk_pkg::SCALED_W;
	localparam int MW  = trk_pkg::MS_W;

	localparam logic [6:0] INST_LIM = 7'(INSTANCES);

	trk_pkg::trk_state_t state_q, state_d;

	logic [trk_pkg::CFG_W-1:0]   min_q;
	logic [trk_pkg::CFG_W-1:0]   factor_q;
	logic [trk_pkg::HEARD_W-1:0] k_q;
	logic [MW-1:0]               cap_q;

	trk_pkg::trk_cmd_t cmd_q;
	logic              ok_q;
	logic [AW-1:0]     addr_q;
	logic [MW-1:0]     start_q;
	logic [MW-1:0]     rnd_q;
	trk_pkg::trk_rec_t rec_q;
	logic [trk_pkg::SCALED_W-1:0] scaled_q;
	logic [MW-1:0]     len_q;
	logic              begin_q;
	logic [MW-1:0]     jitter_q;
	logic              res_do_tx_q;
	logic              res_status_q;
	logic              out_valid_q;
	logic              do_tx_q;
	logic              status_q;

	logic          in_acc;
	logic          tick;
	logic [6:0]    inst_ext;
	logic          ram_re;
	logic          ram_we;
	logic          out_load;
	logic [$bits(trk_pkg::trk_rec_t)-1:0] ram_rdata;
	trk_pkg::trk_rec_t rd_rec;
	trk_pkg::trk_rec_t wr_rec;
	logic [MW-1:0] dsel;
	logic [MW-1:0] now_ms;
	logic [TPW-1:0] tick_bound;
	logic          reached;
	logic [MW:0]   dbl;
	logic [MW-1:0] half;

	logic          div_start;
	logic          div_done;
	logic [MW-2:0] mod_rem;

	trk_pkg::trk_rec_t ev_rec;
	logic [MW-1:0]     ev_len;
	logic              ev_begin;
	logic              ev_write;
	logic              ev_do_tx;
	logic              ev_status;
	logic              ev_half_nz;

	assign in_acc   = in_valid && in_ready;
	assign tick     = in_acc && (trk_pkg::trk_cmd_t'(command) == trk_pkg::CMD_TICK);
	assign inst_ext = {4'b0000, instance_req};
	assign rd_rec   = trk_pkg::trk_rec_t'(ram_rdata);
	assign dsel     = rd_rec.tx_done ? rd_rec.interval_end : rd_rec.tx_point;
	assign reached  = (CW'(scaled_q) < CW'(tick_bound));
	assign dbl      = {rec_q.interval_len, 1'b0};
	assign half     = {1'b0, len_q[MW-1:1]};

	trk_ram #(
		.WIDTH($bits(trk_pkg::trk_rec_t)),
		.DEPTH(INSTANCES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(wr_rec),
		.re   (ram_re),
		.raddr(inst_ext[AW-1:0]),
		.rdata(ram_rdata)
	);

	trk_time #(
		.TICK_PERIOD_US(TICK_PERIOD_US)
	) u_time (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.now_ms    (now_ms),
		.tick_bound(tick_bound)
	);

	trk_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rnd_q),
		.divisor  (ev_len[MW-1:1]),
		.done     (div_done),
		.remainder(mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= trk_pkg::RST_MIN;
			factor_q <= trk_pkg::RST_FACTOR;
			k_q      <= trk_pkg::RST_K;
			cap_q    <= MW'(trk_pkg::RST_MIN) * MW'(trk_pkg::RST_FACTOR);
		end else begin
			cap_q <= MW'(min_q) * MW'(factor_q);
			if (cfg_we) begin
				case (cfg_index)
					trk_pkg::CFG_IDX_MIN:    min_q    <= cfg_wdata;
					trk_pkg::CFG_IDX_FACTOR: factor_q <= cfg_wdata;
					trk_pkg::CFG_IDX_K:      k_q      <= cfg_wdata[trk_pkg::HEARD_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		ev_rec    = rec_q;
		ev_len    = rec_q.interval_len;
		ev_begin  = 1'b0;
		ev_write  = 1'b0;
		ev_do_tx  = 1'b0;
		ev_status = 1'b0;
		if (ok_q) begin
			case (cmd_q)
				trk_pkg::CMD_INIT: begin
					if (start_q < MW'(min_q) || start_q > cap_q) begin
						ev_status = 1'b1;
					end else begin
						ev_len   = start_q;
						ev_begin = 1'b1;
					end
				end
				trk_pkg::CMD_RX_CONS: begin
					if (rec_q.heard != '1) begin
						ev_rec.heard = rec_q.heard + 1'b1;
					end
					ev_write = 1'b1;
				end
				trk_pkg::CMD_RX_INCONS: begin
					if (rec_q.interval_len > MW'(min_q)) begin
						ev_len   = MW'(min_q);
						ev_begin = 1'b1;
					end
				end
				trk_pkg::CMD_RESET: begin
					ev_len   = MW'(min_q);
					ev_begin = 1'b1;
				end
				trk_pkg::CMD_TX_REG: begin
					ev_rec.tx_done = 1'b1;
					ev_write       = 1'b1;
				end
				trk_pkg::CMD_STEP: begin
					if (rec_q.tx_done) begin
						if (reached) begin
							ev_len   = (dbl < {1'b0, cap_q}) ? dbl[MW-1:0] : cap_q;
							ev_begin = 1'b1;
						end
					end else if (reached) begin
						if (rec_q.heard < k_q) begin
							ev_do_tx = 1'b1;
						end else begin
							ev_rec.tx_done = 1'b1;
							ev_write       = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
		ev_half_nz = (ev_len[MW-1:1] != '0);
	end

	always_comb begin
		wr_rec = rec_q;
		if (begin_q) begin
			wr_rec.interval_len = len_q;
			wr_rec.tx_point     = now_ms + half + jitter_q;
			wr_rec.interval_end = now_ms + len_q;
			wr_rec.heard        = '0;
			wr_rec.tx_done      = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			trk_pkg::S_IDLE: begin
				if (in_valid) begin
					if (trk_pkg::trk_cmd_t'(command) == trk_pkg::CMD_TICK) begin
						state_d = trk_pkg::S_DONE;
					end else begin
						state_d = trk_pkg::S_READ;
					end
				end
			end
			trk_pkg::S_READ: state_d = trk_pkg::S_EVAL;
			trk_pkg::S_EVAL: begin
				if (ev_begin) begin
					state_d = ev_half_nz ? trk_pkg::S_DIV : trk_pkg::S_WRITE;
				end else if (ev_write) begin
					state_d = trk_pkg::S_WRITE;
				end else begin
					state_d = trk_pkg::S_DONE;
				end
			end
			trk_pkg::S_DIV: begin
				if (div_done) begin
					state_d = trk_pkg::S_WRITE;
				end
			end
			trk_pkg::S_WRITE: state_d = trk_pkg::S_DONE;
			trk_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = trk_pkg::S_IDLE;
				end
			end
			default: state_d = trk_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == trk_pkg::S_IDLE);
		ram_re    = in_valid && (state_q == trk_pkg::S_IDLE);
		ram_we    = (state_q == trk_pkg::S_WRITE);
		div_start = (state_q == trk_pkg::S_EVAL) && ev_begin && ev_half_nz;
		out_load  = (state_q == trk_pkg::S_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= trk_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q        <= trk_pkg::trk_cmd_t'(command);
			ok_q         <= (inst_ext < INST_LIM);
			addr_q       <= inst_ext[AW-1:0];
			start_q      <= start_interval_ms;
			rnd_q        <= random_word;
			res_do_tx_q  <= 1'b0;
			res_status_q <= 1'b0;
		end
		if (state_q == trk_pkg::S_READ) begin
			rec_q    <= rd_rec;
			scaled_q <= trk_pkg::SCALED_W'(dsel) * trk_pkg::SCALED_W'(trk_pkg::US_PER_MS);
		end
		if (state_q == trk_pkg::S_EVAL) begin
			rec_q        <= ev_rec;
			len_q        <= ev_len;
			begin_q      <= ev_begin;
			jitter_q     <= '0;
			res_do_tx_q  <= ev_do_tx;
			res_status_q <= ev_status;
		end
		if (state_q == trk_pkg::S_DIV && div_done) begin
			jitter_q <= {1'b0, mod_rem};
		end
		if (out_load) begin
			do_tx_q  <= res_do_tx_q;
			status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign do_tx     = do_tx_q;
	assign status    = status_q;

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while one is in work");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == trk_pkg::S_DIV)
		else $error("remainder unit finished outside of its wait state");

	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(do_tx && status))
		else $error("transmit request and init error in one result");

	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == trk_pkg::S_WRITE |=> state_q == trk_pkg::S_DONE && !ram_we)
		else $error("memory write not followed by result");

endmodule

// ===== src/trk_ram.sv =====
// ----------------------------------------------------------------------------
// trk_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module trk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/trk_mod.sv =====
// ----------------------------------------------------------------------------
// trk_mod
// Restoring remainder unit: one quotient bit per cycle for a 32-bit dividend.
// ----------------------------------------------------------------------------
module trk_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [trk_pkg::MS_W-1:0]   dividend,
	input  logic [trk_pkg::MS_W-2:0]   divisor,
	output logic                       done,
	output logic [trk_pkg::MS_W-2:0]   remainder
);

	localparam int CNT_W = $clog2(trk_pkg::MS_W);

	logic                     busy_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [trk_pkg::MS_W-1:0] shift_q;
	logic [trk_pkg::MS_W-2:0] rem_q;
	logic [trk_pkg::MS_W-2:0] div_q;
	logic [trk_pkg::MS_W-1:0] trial;
	logic [trk_pkg::MS_W:0]   diff;

	assign trial = {rem_q, shift_q[trk_pkg::MS_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
			div_q   <= divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[trk_pkg::MS_W-2:0], 1'b0};
			if (diff[trk_pkg::MS_W]) begin
				rem_q <= trial[trk_pkg::MS_W-2:0];
			end else begin
				rem_q <= diff[trk_pkg::MS_W-2:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== src/trk_time.sv =====
// ----------------------------------------------------------------------------
// trk_time
// Global tick counter with the current time in ms and the scaled tick bound
// used for deadline checks, both kept incrementally.
// ----------------------------------------------------------------------------
module trk_time #(
	parameter int TICK_PERIOD_US = 1000
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           tick,
	output logic [trk_pkg::MS_W-1:0]                       now_ms,
	output logic [trk_pkg::MS_W+$clog2(TICK_PERIOD_US+1)-1:0] tick_bound
);

	localparam int PW       = $clog2(TICK_PERIOD_US + 1);
	localparam int TPW      = trk_pkg::MS_W + PW;
	localparam int MS_STEP  = TICK_PERIOD_US / trk_pkg::US_PER_MS;
	localparam int REM_STEP = TICK_PERIOD_US % trk_pkg::US_PER_MS;

	localparam logic [TPW-1:0]            PERIOD   = TPW'(TICK_PERIOD_US);
	localparam logic [trk_pkg::MS_W-1:0]  MS_INC   = trk_pkg::MS_W'(MS_STEP);
	localparam logic [10:0]               REM_INC  = 11'(REM_STEP);
	localparam logic [10:0]               REM_WRAP = 11'(trk_pkg::US_PER_MS);

	logic [trk_pkg::MS_W-1:0] tick_q;
	logic [trk_pkg::MS_W-1:0] now_q;
	logic [9:0]               rem_q;
	logic [TPW-1:0]           bound_q;
	logic [10:0]              rem_sum;
	logic                     carry;

	assign rem_sum = {1'b0, rem_q} + REM_INC;
	assign carry   = (rem_sum >= REM_WRAP);

	// The bound holds period * (tick_count + 1): a deadline d is reached when
	// 1000 * d is below it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			now_q   <= '0;
			rem_q   <= '0;
			bound_q <= PERIOD;
		end else if (tick) begin
			if (tick_q == '1) begin
				tick_q  <= '0;
				now_q   <= '0;
				rem_q   <= '0;
				bound_q <= PERIOD;
			end else begin
				tick_q  <= tick_q + 1'b1;
				now_q   <= now_q + MS_INC + trk_pkg::MS_W'(carry);
				rem_q   <= carry ? 10'(rem_sum - REM_WRAP) : rem_sum[9:0];
				bound_q <= bound_q + PERIOD;
			end
		end
	end

	assign now_ms     = now_q;
	assign tick_bound = bound_q;

endmodule
